// File: src/mie_pkg.sv
// Shared types, control-word layout and microprogram for the modular inverse block.
// No dependencies; every other file imports this package.
package mie_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DATA_W);
	localparam int STEP_W = 4;

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [STEP_W-1:0] step_t;

	typedef struct packed {
		word_t value;
		word_t modulus;
	} in_item_t;

	typedef struct packed {
		word_t inverse;
		logic  no_inverse;
	} out_item_t;

	// Datapath micro-operations
	typedef enum logic [3:0] {
		OP_WAIT_IN,
		OP_NOP,
		OP_DIV_INIT,
		OP_ALIGN,
		OP_DIV_STEP,
		OP_EUC_INIT,
		OP_EUC_UPDATE,
		OP_RESULT,
		OP_RES_NOINV,
		OP_RES_ZERO
	} op_t;

	// Jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_R1_ZERO,
		C_R1_ONE,
		C_ALIGN_OK,
		C_K_NONZERO,
		C_R0_NOT_ONE
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	typedef struct packed {
		op_t  op;
		logic en;
	} dp_ctrl_t;

	typedef struct packed {
		logic r1_zero;
		logic r1_one;
		logic r0_not_one;
		logic align_ok;
		logic k_nonzero;
	} dp_stat_t;

	// Program labels
	localparam step_t L_START  = step_t'(0);
	localparam step_t L_RED_AL = step_t'(4);
	localparam step_t L_RED_DV = step_t'(5);
	localparam step_t L_LOOP   = step_t'(7);
	localparam step_t L_EUC_AL = step_t'(9);
	localparam step_t L_EUC_DV = step_t'(10);
	localparam step_t L_FINISH = step_t'(12);
	localparam step_t L_NOINV  = step_t'(14);
	localparam step_t L_ZERO   = step_t'(15);

	// Microprogram ROM: a true condition jumps to target, otherwise fall through
	function automatic uword_t ucode(input step_t step);
		uword_t w;
		w = '{op: OP_NOP, cond: C_NEVER, target: L_START};
		case (step)
			// take a transaction, screen the special moduli
			step_t'(0):  w = '{op: OP_WAIT_IN,    cond: C_NEVER,      target: L_START};
			step_t'(1):  w = '{op: OP_NOP,        cond: C_R1_ZERO,    target: L_NOINV};
			step_t'(2):  w = '{op: OP_NOP,        cond: C_R1_ONE,     target: L_ZERO};
			// reduce value modulo modulus
			step_t'(3):  w = '{op: OP_DIV_INIT,   cond: C_NEVER,      target: L_START};
			step_t'(4):  w = '{op: OP_ALIGN,      cond: C_ALIGN_OK,   target: L_RED_AL};
			step_t'(5):  w = '{op: OP_DIV_STEP,   cond: C_K_NONZERO,  target: L_RED_DV};
			step_t'(6):  w = '{op: OP_EUC_INIT,   cond: C_NEVER,      target: L_START};
			// Euclid loop
			step_t'(7):  w = '{op: OP_NOP,        cond: C_R1_ZERO,    target: L_FINISH};
			step_t'(8):  w = '{op: OP_DIV_INIT,   cond: C_NEVER,      target: L_START};
			step_t'(9):  w = '{op: OP_ALIGN,      cond: C_ALIGN_OK,   target: L_EUC_AL};
			step_t'(10): w = '{op: OP_DIV_STEP,   cond: C_K_NONZERO,  target: L_EUC_DV};
			step_t'(11): w = '{op: OP_EUC_UPDATE, cond: C_ALWAYS,     target: L_LOOP};
			// results
			step_t'(12): w = '{op: OP_NOP,        cond: C_R0_NOT_ONE, target: L_NOINV};
			step_t'(13): w = '{op: OP_RESULT,     cond: C_ALWAYS,     target: L_START};
			step_t'(14): w = '{op: OP_RES_NOINV,  cond: C_ALWAYS,     target: L_START};
			step_t'(15): w = '{op: OP_RES_ZERO,   cond: C_ALWAYS,     target: L_START};
			default:     w = '{op: OP_NOP,        cond: C_ALWAYS,     target: L_START};
		endcase
		return w;
	endfunction

endpackage

// File: src/mie_dp.sv
// Datapath of the modular inverse block: Euclid registers, shift-subtract divider
// and coefficient accumulator. Depends on mie_pkg; driven by the sequencer in the top level.
module mie_dp
	import mie_pkg::*;
(
	input  logic     clk,
	input  dp_ctrl_t ctrl,
	input  in_item_t req,
	output dp_stat_t stat,
	output out_item_t result
);

	word_t r0_q, r1_q, m_q, t0_q, t1_q, d_q, rem_q, acc_q;
	cnt_t  k_q;
	logic  odd_q;

	logic [DATA_W:0] d_dbl;
	logic            ge;
	word_t           rem_sub;
	word_t           acc_add;
	word_t           inv_mag;

	// Divider compares and adds
	always_comb begin
		d_dbl   = {d_q, 1'b0};
		ge      = (rem_q >= d_q);
		rem_sub = rem_q - d_q;
		acc_add = {acc_q[DATA_W-2:0], 1'b0} + (ge ? t1_q : '0);
	end

	// Flags for the sequencer
	always_comb begin
		stat.r1_zero    = (r1_q == '0);
		stat.r1_one     = (r1_q == word_t'(1));
		stat.r0_not_one = (r0_q != word_t'(1));
		stat.align_ok   = (d_dbl <= {1'b0, rem_q});
		stat.k_nonzero  = (k_q != '0);
	end

	// Fold the signed coefficient into range 0 .. modulus-1
	always_comb begin
		if ((t0_q == '0) || (t0_q == m_q)) begin
			inv_mag = '0;
		end else if (odd_q) begin
			inv_mag = t0_q;
		end else begin
			inv_mag = m_q - t0_q;
		end
		case (ctrl.op)
			OP_RESULT:    result = '{inverse: inv_mag, no_inverse: 1'b0};
			OP_RES_NOINV: result = '{inverse: '0, no_inverse: 1'b1};
			default:      result = '{inverse: '0, no_inverse: 1'b0};
		endcase
	end

	// Advance the datapath by one micro-operation
	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			case (ctrl.op)
				OP_WAIT_IN: begin
					r0_q <= req.value;
					r1_q <= req.modulus;
					m_q  <= req.modulus;
				end
				OP_DIV_INIT: begin
					d_q   <= r1_q;
					rem_q <= r0_q;
					acc_q <= '0;
					k_q   <= '0;
				end
				OP_ALIGN: begin
					if (stat.align_ok) begin
						d_q <= d_dbl[DATA_W-1:0];
						k_q <= k_q + cnt_t'(1);
					end
				end
				OP_DIV_STEP: begin
					if (ge) begin
						rem_q <= rem_sub;
					end
					acc_q <= acc_add;
					d_q   <= d_q >> 1;
					if (stat.k_nonzero) begin
						k_q <= k_q - cnt_t'(1);
					end
				end
				OP_EUC_INIT: begin
					r0_q  <= r1_q;
					r1_q  <= rem_q;
					t0_q  <= '0;
					t1_q  <= word_t'(1);
					odd_q <= 1'b0;
				end
				OP_EUC_UPDATE: begin
					r0_q  <= r1_q;
					r1_q  <= rem_q;
					t0_q  <= t1_q;
					t1_q  <= t0_q + acc_q;
					odd_q <= ~odd_q;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: src/modular_inverse_euclid_top.sv
// Top level of the modular inverse block: microprogram sequencer and result register.
// Depends on mie_pkg and mie_dp.
//
//   channel | valid     | stall     | payload           | direction
//   request | req_valid | req_stall | req (in_item_t)   | into block
//   result  | rsp_valid | rsp_stall | rsp (out_item_t)  | out of block
//
// One transaction at a time. A Euclid step with a quotient of b bits runs b align steps,
// b divide steps, plus loop test, divider load and coefficient update.
// Reducing value by modulus runs align and divide steps between a divider load and the Euclid setup.
// Modulus 0 goes straight to a no-inverse result, modulus 1 straight to a zero result.
// Reset clears the step counter and the result valid; no clearing pass.
// A stalled result holds its register; the next request is taken as soon as the result is loaded.
module modular_inverse_euclid_top
	import mie_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_item_t rsp
);

	step_t     step_q;
	step_t     step_d;
	uword_t    uw;
	logic      is_res;
	logic      go;
	logic      hit;
	dp_ctrl_t  ctrl;
	dp_stat_t  stat;
	out_item_t result;
	logic      rsp_valid_q;
	out_item_t rsp_q;

	mie_dp u_dp (
		.clk    (clk),
		.ctrl   (ctrl),
		.req    (req),
		.stat   (stat),
		.result (result)
	);

	// Decode the current control word
	always_comb begin
		uw     = ucode(step_q);
		is_res = (uw.op inside {OP_RESULT, OP_RES_NOINV, OP_RES_ZERO});
		if (uw.op == OP_WAIT_IN) begin
			go = req_valid;
		end else if (is_res) begin
			go = !rsp_valid_q || !rsp_stall;
		end else begin
			go = 1'b1;
		end
		ctrl.op = uw.op;
		ctrl.en = go;
	end

	// Evaluate the jump condition and pick the next step
	always_comb begin
		case (uw.cond)
			C_NEVER:      hit = 1'b0;
			C_ALWAYS:     hit = 1'b1;
			C_R1_ZERO:    hit = stat.r1_zero;
			C_R1_ONE:     hit = stat.r1_one;
			C_ALIGN_OK:   hit = stat.align_ok;
			C_K_NONZERO:  hit = stat.k_nonzero;
			C_R0_NOT_ONE: hit = stat.r0_not_one;
			default:      hit = 1'b0;
		endcase
		if (!go) begin
			step_d = step_q;
		end else if (hit) begin
			step_d = uw.target;
		end else begin
			step_d = step_q + step_t'(1);
		end
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= L_START;
		end else begin
			step_q <= step_d;
		end
	end

	// Result register: load on a result step, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (is_res && go) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_res && go) begin
			rsp_q <= result;
		end
	end

	assign req_stall = (uw.op != OP_WAIT_IN);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	a_noinv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.no_inverse |-> rsp.inverse == '0)
		else $error("no_inverse result carries a nonzero inverse");

	a_accept_step: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> step_q == step_t'(1))
		else $error("sequencer did not leave the wait step after a transaction");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(is_res && go))
		else $error("result valid rose without a result step");
`endif

endmodule
